[sv/cpzf_pkg.sv]
// Shared constants, opcodes, register indexes and the edge unit interface types.
// Used by the edge evaluator and the top level of the polygon zone filter.
`default_nettype none
package cpzf_pkg;

    localparam int ZONES_DEF    = 8;
    localparam int VERTICES_DEF = 16;
    localparam int FRAC_BITS    = 16;

    // Default clearance of 0.15 m, rounded to the nearest step.
    localparam logic [30:0] MARGIN_RESET = 31'(((15 << FRAC_BITS) + 50) / 100);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    localparam logic CFG_FILTER_ENABLE = 1'b0;
    localparam logic CFG_MARGIN        = 1'b1;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 8;

    // One polygon edge from a to b, with the doubled cell center p.
    typedef struct packed {
        logic        valid;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] bx;
        logic [31:0] by;
        logic [32:0] px;
        logic [32:0] py;
        logic [63:0] m2sq;
    } t_edge_in;

    typedef struct packed {
        logic valid;
        logic toggle;
        logic near;
    } t_edge_out;

endpackage
`default_nettype wire

[sv/cell_polygon_zone_filter.sv]
// Clear and an append to a full zone go straight to the result state, another append
// passes the append state first. With the filter enabled, a test reads the box of each
// nonempty zone and walks its n vertices through the vertex memory, one read a cycle,
// into the 7 stage edge evaluator; it skips zones outside the widened box and stops at a hit.
// A result waits in the output register while the next beat is accepted.
// Synchronous reset empties all zones and loads the register defaults.
`default_nettype none
module cell_polygon_zone_filter import cpzf_pkg::*; #(
    parameter int ZONES    = ZONES_DEF,
    parameter int VERTICES = VERTICES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // zone_index, vertex_x, vertex_y, cell_min_x, cell_min_y, cell_max_x, cell_max_y
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // opcode
    input  wire logic [1:0]            i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // remove, hit_zone, status
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [30:0]           i_cfg_data
);

    localparam int ZW    = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CW    = $clog2(VERTICES + 1);
    localparam int IW    = $clog2(VERTICES + 2);
    localparam int DEPTH = ZONES * VERTICES;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_APPEND = 3'd1;
    localparam logic [2:0] S_ZSTART = 3'd2;
    localparam logic [2:0] S_ZBOX   = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]    r_state;
    logic          r_enable;
    logic [30:0]   r_margin;
    logic [63:0]   r_m2sq;
    logic [CW-1:0] r_cnt [ZONES];

    logic [ZW-1:0] r_zsel, r_k;
    logic [31:0]   r_vx, r_vy, r_cminx, r_cminy, r_cmaxx, r_cmaxy;
    logic [IW-1:0] r_rd_idx;
    logic [CW-1:0] r_edone;
    logic          r_rdv, r_got, r_inside, r_near;
    logic [63:0]   r_prev;
    logic          r_res_remove, r_res_status;
    logic [2:0]    r_res_hit;
    logic          r_out_valid, r_out_remove, r_out_status;
    logic [2:0]    r_out_hit;

    // Vertex memory {y, x} and box memory {max_y, max_x, min_y, min_x}.
    logic [63:0]   vmem [DEPTH];
    logic [127:0]  bmem [ZONES];
    logic [63:0]   r_vq;
    logic [127:0]  r_box_q;

    logic          vm_we, bm_we;
    logic [AW-1:0] vm_waddr, vm_raddr;
    logic [ZW-1:0] bm_raddr;
    logic [127:0]  bm_wdata;

    logic          accept, zok, out_load, k_last;
    logic [2:0]    in_zone;
    logic [ZW-1:0] in_zsel;
    logic [CW-1:0] in_cnt, k_cnt, z_cnt;
    logic [IW-1:0] walk_idx;
    t_edge_in      edge_in;
    t_edge_out     edge_out;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_zone  = i_s_axis_tdata[2:0];
    assign zok      = int'(in_zone) < ZONES;
    assign in_zsel  = ZW'(in_zone);
    assign in_cnt   = r_cnt[in_zsel];
    assign k_cnt    = r_cnt[r_k];
    assign z_cnt    = r_cnt[r_zsel];
    assign k_last   = (r_k == ZW'(ZONES - 1));
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    // The last read of a walk fetches vertex 0 again to close the polygon.
    assign walk_idx = (r_rd_idx == IW'(k_cnt)) ? '0 : r_rd_idx;
    assign vm_we    = accept && (i_s_axis_tuser == OP_APPEND) && zok
                      && (int'(in_cnt) < VERTICES);
    assign vm_waddr = AW'(int'(in_zsel) * VERTICES + int'(in_cnt));
    assign vm_raddr = AW'(int'(r_k) * VERTICES + int'(walk_idx));
    assign bm_raddr = (r_state == S_IDLE) ? in_zsel : r_k;
    assign bm_we    = (r_state == S_APPEND);

    always_comb begin
        logic signed [31:0] x, y, mnx, mny, mxx, mxy;
        x   = $signed(r_vx);
        y   = $signed(r_vy);
        mnx = $signed(r_box_q[31:0]);
        mny = $signed(r_box_q[63:32]);
        mxx = $signed(r_box_q[95:64]);
        mxy = $signed(r_box_q[127:96]);
        if (z_cnt == '0) begin
            bm_wdata = {r_vy, r_vx, r_vy, r_vx};
        end else begin
            bm_wdata[31:0]   = (x < mnx) ? r_vx : r_box_q[31:0];
            bm_wdata[63:32]  = (y < mny) ? r_vy : r_box_q[63:32];
            bm_wdata[95:64]  = (x > mxx) ? r_vx : r_box_q[95:64];
            bm_wdata[127:96] = (y > mxy) ? r_vy : r_box_q[127:96];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            vmem[vm_waddr] <= i_s_axis_tdata[66:3];
        end
        r_vq <= vmem[vm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bmem[r_zsel] <= bm_wdata;
        end
        r_box_q <= bmem[bm_raddr];
    end

    // Box rejection against the zone box widened by the margin.
    logic signed [33:0] mg, lo_x, hi_x, lo_y, hi_y;
    logic               box_reject;

    assign mg   = $signed({3'b0, r_margin});
    assign lo_x = $signed(r_box_q[31:0]) - mg;
    assign lo_y = $signed(r_box_q[63:32]) - mg;
    assign hi_x = $signed(r_box_q[95:64]) + mg;
    assign hi_y = $signed(r_box_q[127:96]) + mg;
    assign box_reject = ($signed(r_cmaxx) < lo_x) || ($signed(r_cminx) > hi_x) ||
                        ($signed(r_cmaxy) < lo_y) || ($signed(r_cminy) > hi_y);

    assign edge_in.valid = (r_state == S_WALK) && r_rdv && r_got;
    assign edge_in.ax    = r_prev[31:0];
    assign edge_in.ay    = r_prev[63:32];
    assign edge_in.bx    = r_vq[31:0];
    assign edge_in.by    = r_vq[63:32];
    assign edge_in.px    = 33'($signed(r_cminx)) + 33'($signed(r_cmaxx));
    assign edge_in.py    = 33'($signed(r_cminy)) + 33'($signed(r_cmaxy));
    assign edge_in.m2sq  = r_m2sq;

    cpzf_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_in),
        .o_edge  (edge_out)
    );

    always_ff @(posedge i_clk) begin
        r_m2sq <= 64'({r_margin, 1'b0}) * 64'({r_margin, 1'b0});
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILTER_ENABLE: r_enable <= i_cfg_data[0];
                CFG_MARGIN:        r_margin <= i_cfg_data;
                default:           r_enable <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rdv       <= 1'b0;
            for (int z = 0; z < ZONES; z++) begin
                r_cnt[z] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_remove <= 1'b0;
                        r_res_hit    <= '0;
                        r_res_status <= 1'b0;
                        r_state      <= S_DONE;
                        case (i_s_axis_tuser)
                            OP_CLEAR: begin
                                if (zok) begin
                                    r_cnt[in_zsel] <= '0;
                                end
                            end
                            OP_APPEND: begin
                                if (zok) begin
                                    if (int'(in_cnt) >= VERTICES) begin
                                        r_res_status <= 1'b1;
                                    end else begin
                                        r_state <= S_APPEND;
                                    end
                                end
                            end
                            OP_TEST: begin
                                if (r_enable) begin
                                    r_k     <= '0;
                                    r_state <= S_ZSTART;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_APPEND: begin
                    r_cnt[r_zsel] <= z_cnt + 1'b1;
                    r_state       <= S_DONE;
                end
                S_ZSTART: begin
                    if (k_cnt == '0) begin
                        if (k_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_state <= S_ZBOX;
                    end
                end
                S_ZBOX: begin
                    r_rd_idx <= '0;
                    r_got    <= 1'b0;
                    r_edone  <= '0;
                    r_inside <= 1'b0;
                    r_near   <= 1'b0;
                    if (!box_reject) begin
                        r_state <= S_WALK;
                    end else if (k_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_ZSTART;
                    end
                end
                S_WALK: begin
                    r_rdv <= (r_rd_idx <= IW'(k_cnt));
                    if (r_rd_idx <= IW'(k_cnt)) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_rdv) begin
                        r_prev <= r_vq;
                        r_got  <= 1'b1;
                    end
                    if (edge_out.valid) begin
                        r_edone  <= r_edone + 1'b1;
                        r_inside <= r_inside ^ edge_out.toggle;
                        r_near   <= r_near | edge_out.near;
                    end
                    // Every edge has left the evaluator once the count is reached.
                    if (r_edone == k_cnt) begin
                        r_rdv <= 1'b0;
                        if (r_inside || r_near) begin
                            r_res_remove <= 1'b1;
                            r_res_hit    <= 3'(r_k);
                            r_state      <= S_DONE;
                        end else if (k_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ZSTART;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_zsel  <= in_zsel;
            r_vx    <= i_s_axis_tdata[34:3];
            r_vy    <= i_s_axis_tdata[66:35];
            r_cminx <= i_s_axis_tdata[98:67];
            r_cminy <= i_s_axis_tdata[130:99];
            r_cmaxx <= i_s_axis_tdata[162:131];
            r_cmaxy <= i_s_axis_tdata[194:163];
        end
        if (out_load) begin
            r_out_remove <= r_res_remove;
            r_out_hit    <= r_res_hit;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b0, r_out_status, r_out_hit, r_out_remove};

    a_edge_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_out.valid |-> (r_state == S_WALK))
        else $error("edge result outside a zone walk");

    a_edges_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_edone <= k_cnt))
        else $error("more edges evaluated than the zone holds");

    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_status && r_out_remove))
        else $error("refused append reported as a hit");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (k_cnt != '0))
        else $error("walk started on an empty zone");

endmodule
`default_nettype wire

[sv/cpzf_edge.sv]
// Seven stage edge evaluator: crossing parity toggle and within-margin test.
// Depends on cpzf_pkg for the edge interface structs.
`default_nettype none
module cpzf_edge import cpzf_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_edge_in  i_edge,
    output t_edge_out      o_edge
);

    // Stage 1: doubled coordinates and differences.
    logic signed [32:0] ax2, ay2, bx2, by2, px, py;
    logic signed [34:0] n1_vx, n1_vy, n1_wx, n1_wy, n1_ux, n1_uy;
    logic signed [34:0] r1_vx, r1_vy, r1_wx, r1_wy, r1_ux, r1_uy;
    logic               r1_v, r1_str;
    logic [63:0]        r1_m2sq;

    assign ax2 = $signed({i_edge.ax, 1'b0});
    assign ay2 = $signed({i_edge.ay, 1'b0});
    assign bx2 = $signed({i_edge.bx, 1'b0});
    assign by2 = $signed({i_edge.by, 1'b0});
    assign px  = $signed(i_edge.px);
    assign py  = $signed(i_edge.py);
    assign n1_vx = bx2 - ax2;
    assign n1_vy = by2 - ay2;
    assign n1_wx = px - ax2;
    assign n1_wy = py - ay2;
    assign n1_ux = px - bx2;
    assign n1_uy = py - by2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_edge.valid;
        end
        r1_vx   <= n1_vx;
        r1_vy   <= n1_vy;
        r1_wx   <= n1_wx;
        r1_wy   <= n1_wy;
        r1_ux   <= n1_ux;
        r1_uy   <= n1_uy;
        r1_str  <= (ay2 > py) != (by2 > py);
        r1_m2sq <= i_edge.m2sq;
    end

    // Stage 2: all narrow products side by side.
    logic signed [69:0] r2_wxvx, r2_wyvy, r2_vxvx, r2_vyvy, r2_wxwx;
    logic signed [69:0] r2_wywy, r2_uxux, r2_uyuy, r2_vxwy, r2_vywx;
    logic               r2_v, r2_str, r2_vypos, r2_vyneg;
    logic [63:0]        r2_m2sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_wxvx  <= r1_wx * r1_vx;
        r2_wyvy  <= r1_wy * r1_vy;
        r2_vxvx  <= r1_vx * r1_vx;
        r2_vyvy  <= r1_vy * r1_vy;
        r2_wxwx  <= r1_wx * r1_wx;
        r2_wywy  <= r1_wy * r1_wy;
        r2_uxux  <= r1_ux * r1_ux;
        r2_uyuy  <= r1_uy * r1_uy;
        r2_vxwy  <= r1_vx * r1_wy;
        r2_vywx  <= r1_vy * r1_wx;
        r2_str   <= r1_str;
        r2_vypos <= r1_vy > 35'sd0;
        r2_vyneg <= r1_vy < 35'sd0;
        r2_m2sq  <= r1_m2sq;
    end

    // Stage 3: dot product, squared lengths and the cross product.
    logic signed [70:0] n3_crs;
    logic signed [70:0] r3_dot, r3_lensq, r3_d0, r3_d1, r3_crs;
    logic               r3_v, r3_tog;
    logic [63:0]        r3_m2sq;

    assign n3_crs = r2_vxwy - r2_vywx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_dot   <= r2_wxvx + r2_wyvy;
        r3_lensq <= r2_vxvx + r2_vyvy;
        r3_d0    <= r2_wxwx + r2_wywy;
        r3_d1    <= r2_uxux + r2_uyuy;
        r3_crs   <= n3_crs;
        // The crossing orientation is the sign of the cross product, taken with the sign of vy.
        r3_tog   <= r2_str && ((r2_vypos && n3_crs > 71'sd0) ||
                               (r2_vyneg && n3_crs < 71'sd0));
        r3_m2sq  <= r2_m2sq;
    end

    // Stage 4: magnitude of the cross product and the endpoint decisions.
    logic signed [70:0] m2sq_s, n4_neg;
    logic [67:0]        r4_cabs, r4_lensq;
    logic               r4_v, r4_tog, r4_dotle0, r4_dotge, r4_d0le, r4_d1le;
    logic [63:0]        r4_m2sq;

    assign m2sq_s = $signed({7'b0, r3_m2sq});
    assign n4_neg = -r3_crs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_cabs   <= r3_crs[70] ? n4_neg[67:0] : r3_crs[67:0];
        r4_lensq  <= r3_lensq[67:0];
        r4_tog    <= r3_tog;
        r4_dotle0 <= r3_dot <= 71'sd0;
        r4_dotge  <= r3_dot >= r3_lensq;
        r4_d0le   <= r3_d0 <= m2sq_s;
        r4_d1le   <= r3_d1 <= m2sq_s;
        r4_m2sq   <= r3_m2sq;
    end

    // Stage 5: partial products of the squared cross product and of margin times length.
    logic [34:0] c_lo, c_hi, m_lo, m_hi, l_lo, l_hi;
    logic [69:0] r5_cll, r5_clh, r5_chh, r5_ll, r5_lh, r5_hl, r5_hh;
    logic        r5_v, r5_tog, r5_dotle0, r5_dotge, r5_d0le, r5_d1le;

    assign c_lo = r4_cabs[34:0];
    assign c_hi = {2'b0, r4_cabs[67:35]};
    assign m_lo = r4_m2sq[34:0];
    assign m_hi = {6'b0, r4_m2sq[63:35]};
    assign l_lo = r4_lensq[34:0];
    assign l_hi = {2'b0, r4_lensq[67:35]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_cll    <= c_lo * c_lo;
        r5_clh    <= c_lo * c_hi;
        r5_chh    <= c_hi * c_hi;
        r5_ll     <= m_lo * l_lo;
        r5_lh     <= m_lo * l_hi;
        r5_hl     <= m_hi * l_lo;
        r5_hh     <= m_hi * l_hi;
        r5_tog    <= r4_tog;
        r5_dotle0 <= r4_dotle0;
        r5_dotge  <= r4_dotge;
        r5_d0le   <= r4_d0le;
        r5_d1le   <= r4_d1le;
    end

    // Stage 6: assemble the squared cross product and margin times length.
    logic [135:0] r6_c2, r6_ml;
    logic         r6_v, r6_tog, r6_dotle0, r6_dotge, r6_d0le, r6_d1le;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_c2 <= 136'(r5_cll) + (136'(r5_clh) << 36) + (136'(r5_chh) << 70);
        r6_ml <= 136'(r5_ll) + ((136'(r5_lh) + 136'(r5_hl)) << 35)
                 + (136'(r5_hh) << 70);
        r6_tog    <= r5_tog;
        r6_dotle0 <= r5_dotle0;
        r6_dotge  <= r5_dotge;
        r6_d0le   <= r5_d0le;
        r6_d1le   <= r5_d1le;
    end

    // Stage 7: pick the distance that applies to the closed segment.
    logic r7_v, r7_tog, r7_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_tog  <= r6_tog;
        r7_near <= r6_dotle0 ? r6_d0le : (r6_dotge ? r6_d1le : (r6_c2 <= r6_ml));
    end

    assign o_edge.valid  = r7_v;
    assign o_edge.toggle = r7_tog;
    assign o_edge.near   = r7_near;

endmodule
`default_nettype wire
